// ----- rtl/core/sdf_pkg.sv -----
// ----------------------------------------------------------------------------
// sdf_pkg
// Shared widths, codes and types of the stream duplicate filter.
// ----------------------------------------------------------------------------
package sdf_pkg;

  // One stored entry: valid bit over a 32-bit value
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned ENTRY_W     = VALUE_W + 1;

  // Distinct count, saturating
  localparam int unsigned COUNT_W     = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // Stream widths
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned OUT_TUSER_W = 2;

  // Outcome of a bucket row lookup
  typedef struct packed {
    logic found;     // value already held in the row
    logic has_free;  // row has at least one invalid slot
  } match_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_HASH   = 4'b0100,
    S_UPDATE = 4'b1000
  } state_t;

endpackage

// ----- rtl/core/sdf_bucket_mod.sv -----
// ----------------------------------------------------------------------------
// sdf_bucket_mod
// Bucket index unit: value mod BUCKETS. A mask for a power-of-two bucket
// count, otherwise a multiplication by the rounded-up reciprocal of the
// bucket count, a back-multiplication and a subtraction, each registered.
// ----------------------------------------------------------------------------
module sdf_bucket_mod #(
  parameter int unsigned BUCKETS = 256,
  localparam int unsigned IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [31:0]      value,
  output logic             done,
  output logic [IDX_W-1:0] bucket
);
  import sdf_pkg::*;

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

  generate
    if (POW2) begin : g_mask
      // Take the low bits, registered
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          bucket <= IDX_W'(value & 32'(BUCKETS - 1));
        end
      end
    end else begin : g_recip
      // Reciprocal rounded up and scaled by 2^(32+IDX_W); exact for 32-bit values
      localparam int unsigned SHIFT = 32 + IDX_W;
      localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
      localparam logic [32:0] RECIP = RECIP_FULL[32:0];

      logic [31:0] value_q;
      logic [64:0] product;
      logic [31:0] quot_mul;
      logic [1:0]  stage;

      // Advance the stage valid bits
      always_ff @(posedge clk) begin
        if (rst) begin
          stage <= '0;
          done  <= 1'b0;
        end else begin
          stage <= {stage[0], start};
          done  <= stage[1];
        end
      end

      // Estimate the quotient, multiply it back, keep the remainder
      always_ff @(posedge clk) begin
        if (start) begin
          value_q <= value;
          product <= {33'd0, value} * {32'd0, RECIP};
        end
        if (stage[0]) begin
          quot_mul <= 32'(product >> SHIFT) * 32'(BUCKETS);
        end
        if (stage[1]) begin
          bucket <= IDX_W'(value_q - quot_mul);
        end
      end
    end
  endgenerate

endmodule

// ----- rtl/core/sdf_bucket_mem.sv -----
// ----------------------------------------------------------------------------
// sdf_bucket_mem
// Bucket row memory: one row of SLOTS entries per bucket, one write port
// and one read port with registered read data.
// ----------------------------------------------------------------------------
module sdf_bucket_mem #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned SLOTS   = 4,
  localparam int unsigned IDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  localparam int unsigned ROW_W  = SLOTS * sdf_pkg::ENTRY_W
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [ROW_W-1:0] wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ROW_W-1:0] rd_data
);
  import sdf_pkg::*;

  logic [ROW_W-1:0] mem [BUCKETS];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/sdf_row_match.sv -----
// ----------------------------------------------------------------------------
// sdf_row_match
// Compare a value against every slot of a bucket row and build the row
// with the value placed in the lowest free slot.
// ----------------------------------------------------------------------------
module sdf_row_match #(
  parameter int unsigned SLOTS  = 4,
  localparam int unsigned ROW_W = SLOTS * sdf_pkg::ENTRY_W
) (
  input  logic [ROW_W-1:0]          row,
  input  logic [sdf_pkg::VALUE_W-1:0] value,
  output sdf_pkg::match_t           match,
  output logic [ROW_W-1:0]          row_next
);
  import sdf_pkg::*;

  always_comb begin
    logic [ENTRY_W-1:0] slot;
    logic found;
    logic has_free;
    found    = 1'b0;
    has_free = 1'b0;
    row_next = row;
    for (int s = 0; s < SLOTS; s++) begin
      slot = row[s*ENTRY_W +: ENTRY_W];
      if (slot[ENTRY_W-1]) begin
        // Hit on a valid entry
        if (slot[VALUE_W-1:0] == value) begin
          found = 1'b1;
        end
      end else if (!has_free) begin
        // Claim the lowest free slot
        has_free = 1'b1;
        row_next[s*ENTRY_W +: ENTRY_W] = {1'b1, value};
      end
    end
    match.found    = found;
    match.has_free = has_free;
  end

endmodule

// ----- rtl/core/stream_duplicate_filter_core.sv -----
// ----------------------------------------------------------------------------
// stream_duplicate_filter_core
// Hash-set deduplication of a stream of 32-bit values.
// ----------------------------------------------------------------------------
// Each input beat carries a value; each output beat returns it with is_first
// (not seen before), bucket_full (new but its bucket had no free slot, so it
// was not stored) and the distinct count after this beat, saturating at
// 2047. The set is BUCKETS rows of SLOTS entries in one memory, bucket =
// value mod BUCKETS. One value is processed at a time: with a power-of-two
// BUCKETS the steps are accept, row read, compare and write back; otherwise
// the reciprocal remainder unit adds its registered steps before the row read.
// A result waiting on m_tready holds the write-back step, and no new beat is
// accepted meanwhile. After reset a clearing pass writes every row, one per
// cycle, before the first beat is accepted. Since the next row read always
// follows the previous write-back, no two accesses to one row overlap.
module stream_duplicate_filter_core #(
  parameter int unsigned BUCKETS = 256,
  parameter int unsigned SLOTS   = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] value_out, [42:32] distinct_count, rest zero
  output logic [1:0]  m_tuser    // [0] is_first, [1] bucket_full
);
  import sdf_pkg::*;

  localparam int unsigned IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned ROW_W = SLOTS * ENTRY_W;

  state_t             state;
  logic [IDX_W-1:0]   clr_addr;
  logic [VALUE_W-1:0] value;
  logic [IDX_W-1:0]   bucket;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;

  logic               accept;
  logic               mod_done;
  logic [IDX_W-1:0]   mod_bucket;
  logic [ROW_W-1:0]   rd_data;
  logic [ROW_W-1:0]   row_next;
  match_t             match;
  logic               out_load;
  logic               insert;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ROW_W-1:0]   wr_data;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_load = (state == S_UPDATE) && (!m_tvalid || m_tready);
  assign insert   = out_load && !match.found && match.has_free;

  // Bucket index
  sdf_bucket_mod #(
    .BUCKETS (BUCKETS)
  ) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .value  (s_tdata),
    .done   (mod_done),
    .bucket (mod_bucket)
  );

  // Write port shared by the clearing pass and the write-back
  always_comb begin
    wr_en   = (state == S_CLEAR) || insert;
    wr_addr = (state == S_CLEAR) ? clr_addr : bucket;
    wr_data = (state == S_CLEAR) ? '0 : row_next;
  end

  sdf_bucket_mem #(
    .BUCKETS (BUCKETS),
    .SLOTS   (SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (mod_done),
    .rd_addr (mod_bucket),
    .rd_data (rd_data)
  );

  sdf_row_match #(
    .SLOTS (SLOTS)
  ) u_match (
    .row      (rd_data),
    .value    (value),
    .match    (match),
    .row_next (row_next)
  );

  // Count a stored value, saturate at the top
  always_comb begin
    count_next = count;
    if (insert && (count != COUNT_MAX)) begin
      count_next = count + 11'd1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      count    <= '0;
    end else begin
      count <= count_next;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_HASH;
          end
        end
        S_HASH: begin
          if (mod_done) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // Hold the value and its bucket for the write-back
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= s_tdata;
    end
    if (mod_done) begin
      bucket <= mod_bucket;
    end
  end

  // Output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata    <= {5'd0, count_next, value};
      m_tuser[0] <= !match.found;
      m_tuser[1] <= !match.found && !match.has_free;
    end
  end

`ifndef SYNTHESIS
  a_wr_owner: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || state == S_UPDATE))
    else $error("row write outside clearing pass or write-back");

  a_mod_in_hash: assert property (@(posedge clk) disable iff (rst)
    mod_done |-> (state == S_HASH))
    else $error("bucket index ready outside hash state");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |=> (count == $past(count) || count == $past(count) + 11'd1))
    else $error("distinct count moved by more than one");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!m_tvalid || m_tready))
    else $error("output beat overwritten while stalled");
`endif

endmodule
